### sv/afw_pkg.sv
// Shared types and constants for the affine window bilinear resampler.
// No dependencies; every other file of the block imports this package.
package afw_pkg;

  // Field widths fixed by the item and register formats
  localparam int PIX_W    = 8;
  localparam int ADDR_W   = 16;
  localparam int COORD_W  = 8;
  localparam int COEF_W   = 18;
  localparam int DIM_W    = 9;
  localparam int CFG_W    = 18;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W   = COEF_W + COORD_W;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH        = 256;
  localparam int DEF_MAX_HEIGHT       = 256;
  localparam int DEF_COEF_FRAC_BITS   = 14;
  localparam int DEF_WEIGHT_FRAC_BITS = 8;

  // Operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

  // Register reset values
  localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd16384;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = 18'sd0;
  localparam logic [DIM_W-1:0]         DIM_RESET = 9'd256;

  typedef struct packed {
    logic                      operation;
    logic [ADDR_W-1:0]         load_addr;
    logic [PIX_W-1:0]          load_pixel;
    logic [COORD_W-1:0]        centre_x;
    logic [COORD_W-1:0]        centre_y;
    logic signed [COORD_W-1:0] off_x;
    logic signed [COORD_W-1:0] off_y;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             out_of_bounds;
  } out_item_t;

  // Control travelling with an item between pipeline modules
  typedef struct packed {
    logic load;
    logic sample;
    logic oob;
  } ctl_t;

endpackage

### sv/affine_window_bilinear_resampler.sv
// Channel   | Ports                         | Transfer
// ----------+-------------------------------+----------------------------------
// items in  | start, busy, item             | edge with start high, busy low
// config    | cfg_we, cfg_index, cfg_data   | edge with cfg_we high
// results   | done, result                  | edge ending the cycle done is high
//
// One item enters per cycle; busy stays low. A sample's result passes through
// three mapping stages, the store read and two blend stages. Loads give no
// result. Reset clears the pipeline valids and the registers; the store has no
// clearing pass. Results cannot be stalled.
module affine_window_bilinear_resampler #(
  parameter int MAX_WIDTH        = afw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT       = afw_pkg::DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS   = afw_pkg::DEF_COEF_FRAC_BITS,
  parameter int WEIGHT_FRAC_BITS = afw_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  afw_pkg::in_item_t                 item,
  input  logic                              cfg_we,
  input  logic [afw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afw_pkg::CFG_W-1:0]         cfg_data,
  output logic                              done,
  output afw_pkg::out_item_t                result
);
  import afw_pkg::*;

  localparam int DWW = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int DWH = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;
  localparam int DW  = (DWW > DWH) ? DWW : DWH;

  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;
  logic [DIM_W-1:0]         image_width, image_height;
  logic [DW-1:0]            width_eff, height_eff;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a       <= COEF_ONE;
      coef_b       <= COEF_ZERO;
      coef_c       <= COEF_ZERO;
      coef_d       <= COEF_ONE;
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_A:       coef_a <= $signed(cfg_data);
        REG_COEF_B:       coef_b <= $signed(cfg_data);
        REG_COEF_C:       coef_c <= $signed(cfg_data);
        REG_COEF_D:       coef_d <= $signed(cfg_data);
        REG_IMAGE_WIDTH:  image_width <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Dimensions in use, limited to the store geometry
  assign width_eff  = (DW'(image_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(image_width);
  assign height_eff = (DW'(image_height) > DW'(MAX_HEIGHT)) ?
                      DW'(MAX_HEIGHT) : DW'(image_height);

  assign busy = 1'b0;

  ctl_t                  ctl;
  logic [ADDR_W-1:0]     addr;
  logic [PIX_W-1:0]      wr_pixel;
  logic [WEIGHT_FRAC_BITS-1:0] frac_p, frac_q;
  logic [PIX_W-1:0]      pix00, pix01, pix10, pix11;

  afw_map #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
    .DW(DW)
  ) u_map (
    .clk(clk),
    .rst(rst),
    .in_vld(start & ~busy),
    .item(item),
    .coef_a(coef_a),
    .coef_b(coef_b),
    .coef_c(coef_c),
    .coef_d(coef_d),
    .width_eff(width_eff),
    .height_eff(height_eff),
    .ctl(ctl),
    .addr(addr),
    .wr_pixel(wr_pixel),
    .frac_p(frac_p),
    .frac_q(frac_q)
  );

  afw_store #(
    .DW(DW)
  ) u_store (
    .clk(clk),
    .ctl(ctl),
    .addr(addr),
    .wr_pixel(wr_pixel),
    .width_eff(width_eff),
    .pix00(pix00),
    .pix01(pix01),
    .pix10(pix10),
    .pix11(pix11)
  );

  afw_blend #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_blend (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .frac_p(frac_p),
    .frac_q(frac_q),
    .pix00(pix00),
    .pix01(pix01),
    .pix10(pix10),
    .pix11(pix11),
    .done(done),
    .result(result)
  );

endmodule

### sv/afw_map.sv
// Coordinate mapping: matrix products, warped position, bounds and store address.
// Three register stages; depends on afw_pkg.
module afw_map #(
  parameter int MAX_WIDTH        = afw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT       = afw_pkg::DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS   = afw_pkg::DEF_COEF_FRAC_BITS,
  parameter int WEIGHT_FRAC_BITS = afw_pkg::DEF_WEIGHT_FRAC_BITS,
  parameter int DW               = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_vld,
  input  afw_pkg::in_item_t                   item,
  input  logic signed [afw_pkg::COEF_W-1:0]   coef_a,
  input  logic signed [afw_pkg::COEF_W-1:0]   coef_b,
  input  logic signed [afw_pkg::COEF_W-1:0]   coef_c,
  input  logic signed [afw_pkg::COEF_W-1:0]   coef_d,
  input  logic [DW-1:0]                       width_eff,
  input  logic [DW-1:0]                       height_eff,
  output afw_pkg::ctl_t                       ctl,
  output logic [afw_pkg::ADDR_W-1:0]          addr,
  output logic [afw_pkg::PIX_W-1:0]           wr_pixel,
  output logic [WEIGHT_FRAC_BITS-1:0]         frac_p,
  output logic [WEIGHT_FRAC_BITS-1:0]         frac_q
);
  import afw_pkg::*;

  localparam int F   = COEF_FRAC_BITS;
  localparam int WF  = WEIGHT_FRAC_BITS;
  localparam int SW  = (((F + COORD_W + 1) > (PROD_W + 1)) ? (F + COORD_W + 1) : (PROD_W + 1)) + 2;
  localparam int IW  = SW - F;
  localparam int CW  = ((IW > DW) ? IW : DW) + 1;
  localparam int SHR = (F >= WF) ? (F - WF) : 0;
  localparam int SHL = (WF > F) ? (WF - F) : 0;
  localparam int FW  = F + WF;

  // Stage 1: products
  logic                      v1, s1;
  logic [ADDR_W-1:0]         la1;
  logic [PIX_W-1:0]          lp1;
  logic [COORD_W-1:0]        cx1, cy1;
  logic signed [PROD_W-1:0]  pa1, pb1, pc1, pd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_vld;
    end
    s1  <= (item.operation == OP_SAMPLE);
    la1 <= item.load_addr;
    lp1 <= item.load_pixel;
    cx1 <= item.centre_x;
    cy1 <= item.centre_y;
    pa1 <= coef_a * item.off_x;
    pb1 <= coef_b * item.off_y;
    pc1 <= coef_c * item.off_x;
    pd1 <= coef_d * item.off_y;
  end

  // Stage 2: warped position in fixed point
  logic                  v2, s2;
  logic [ADDR_W-1:0]     la2;
  logic [PIX_W-1:0]      lp2;
  logic signed [SW-1:0]  xf2, yf2;
  logic signed [SW-1:0]  cxs, cys;

  assign cxs = $signed(SW'(cx1) << F);
  assign cys = $signed(SW'(cy1) << F);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2  <= s1;
    la2 <= la1;
    lp2 <= lp1;
    xf2 <= cxs + SW'(pa1) + SW'(pb1);
    yf2 <= cys - (SW'(pc1) + SW'(pd1));
  end

  // Stage 3: bounds, fractions and top-left address
  logic              neg;
  logic [IW-1:0]     x0, y0;
  logic              x_out, y_out;
  logic [ADDR_W-1:0] y0_a, w_a, addr_next;
  logic [FW-1:0]     fx, fy;

  assign neg   = xf2[SW-1] | yf2[SW-1];
  assign x0    = xf2[SW-1:F];
  assign y0    = yf2[SW-1:F];
  assign x_out = (CW'(x0) + CW'(1)) >= CW'(width_eff);
  assign y_out = (CW'(y0) + CW'(1)) >= CW'(height_eff);
  assign y0_a  = ADDR_W'(y0);
  assign w_a   = ADDR_W'(width_eff);
  assign addr_next = ADDR_W'(y0_a * w_a) + ADDR_W'(x0);
  assign fx    = FW'(xf2[F-1:0]);
  assign fy    = FW'(yf2[F-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.load   <= v2 & ~s2;
      ctl.sample <= v2 & s2;
      ctl.oob    <= neg | x_out | y_out;
    end
    addr     <= s2 ? addr_next : la2;
    wr_pixel <= lp2;
    frac_p   <= WF'((fx >> SHR) << SHL);
    frac_q   <= WF'((fy >> SHR) << SHL);
  end

endmodule

### sv/afw_store.sv
// Pixel store: two banks holding the same image, four registered reads per cycle.
// Loads write both banks in pipeline order; depends on afw_pkg.
module afw_store #(
  parameter int DW = 9
) (
  input  logic                           clk,
  input  afw_pkg::ctl_t                  ctl,
  input  logic [afw_pkg::ADDR_W-1:0]     addr,
  input  logic [afw_pkg::PIX_W-1:0]      wr_pixel,
  input  logic [DW-1:0]                  width_eff,
  output logic [afw_pkg::PIX_W-1:0]      pix00,
  output logic [afw_pkg::PIX_W-1:0]      pix01,
  output logic [afw_pkg::PIX_W-1:0]      pix10,
  output logic [afw_pkg::PIX_W-1:0]      pix11
);
  import afw_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [PIX_W-1:0] bank_top [DEPTH];
  logic [PIX_W-1:0] bank_bot [DEPTH];

  logic [ADDR_W-1:0] a01, a10, a11;

  // Neighbour addresses wrap at the store depth
  assign a01 = addr + ADDR_W'(1);
  assign a10 = addr + ADDR_W'(width_eff);
  assign a11 = a10 + ADDR_W'(1);

  // Upper row bank
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bank_top[addr] <= wr_pixel;
    end
    pix00 <= bank_top[addr];
    pix01 <= bank_top[a01];
  end

  // Lower row bank
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bank_bot[addr] <= wr_pixel;
    end
    pix10 <= bank_bot[a10];
    pix11 <= bank_bot[a11];
  end

endmodule

### sv/afw_blend.sv
// Bilinear blend: weights, truncated weighted terms and wrapped sum.
// Three register stages, first aligned with the store read; depends on afw_pkg.
module afw_blend #(
  parameter int WEIGHT_FRAC_BITS = afw_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  afw_pkg::ctl_t                   ctl,
  input  logic [WEIGHT_FRAC_BITS-1:0]     frac_p,
  input  logic [WEIGHT_FRAC_BITS-1:0]     frac_q,
  input  logic [afw_pkg::PIX_W-1:0]       pix00,
  input  logic [afw_pkg::PIX_W-1:0]       pix01,
  input  logic [afw_pkg::PIX_W-1:0]       pix10,
  input  logic [afw_pkg::PIX_W-1:0]       pix11,
  output logic                            done,
  output afw_pkg::out_item_t              result
);
  import afw_pkg::*;

  localparam int WF = WEIGHT_FRAC_BITS;
  localparam int PW = WF + 1;
  localparam int WW = 2 * PW;
  localparam int TW = PIX_W + WW;

  // Stage A: weights, alongside the store read
  logic [PW-1:0] one_w, pm, qm, pp, qq;
  logic          va, oa;
  logic [WW-1:0] w00, w01, w10, w11;

  assign one_w = PW'(1) << WF;
  assign pm    = one_w - PW'(frac_p);
  assign qm    = one_w - PW'(frac_q);
  assign pp    = PW'(frac_p);
  assign qq    = PW'(frac_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= ctl.sample;
    end
    oa  <= ctl.oob;
    w00 <= pm * qm;
    w01 <= pp * qm;
    w10 <= pm * qq;
    w11 <= pp * qq;
  end

  // Stage B: each term truncated on its own, low byte kept
  logic             vb, ob;
  logic [PIX_W-1:0] t00, t01, t10, t11;
  logic [TW-1:0]    m00, m01, m10, m11;

  assign m00 = TW'(pix00) * TW'(w00);
  assign m01 = TW'(pix01) * TW'(w01);
  assign m10 = TW'(pix10) * TW'(w10);
  assign m11 = TW'(pix11) * TW'(w11);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    ob  <= oa;
    t00 <= PIX_W'(m00 >> (2 * WF));
    t01 <= PIX_W'(m01 >> (2 * WF));
    t10 <= PIX_W'(m10 >> (2 * WF));
    t11 <= PIX_W'(m11 >> (2 * WF));
  end

  // Stage C: wrapped sum and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vb;
    end
    result.out_of_bounds <= ob;
    result.pixel_value   <= ob ? '0 : (t00 + t01 + t10 + t11);
  end

endmodule
